@@ hw/rtl/fprl_pkg.sv @@
// Shared types, constants and the control store of the flash page record log.
package fprl_pkg;

  // Page geometry and word format
  localparam int PAGE_ENTRIES = 240;
  localparam int WORD_BITS    = 32;
  localparam int ADDR_W       = $clog2(PAGE_ENTRIES);
  localparam int PTR_W        = ADDR_W + 1;
  localparam int SUM_W        = ADDR_W + 2;
  localparam int CNT_W        = 7;
  localparam int UPC_W        = 5;

  localparam logic [WORD_BITS-1:0] ERASED_WORD   = '1;
  localparam logic [CNT_W-1:0]     PAYLOAD_RESET = CNT_W'(5);

  // Words on the ports
  typedef struct packed {
    logic        command;
    logic [31:0] word_value;
    logic [6:0]  word_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        record_found;
    logic        page_erased;
    logic        record_done;
  } out_item_t;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // Control word fields
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IS_READ,
    C_OPEN,
    C_SLOT_OUT,
    C_HDR_ERASED,
    C_HDR_NONZERO,
    C_LAST_SLOT,
    C_IDX_OUT
  } cond_t;

  typedef enum logic [1:0] {M_NONE, M_READ, M_WRITE} mem_op_t;
  typedef enum logic [1:0] {A_BASE, A_NEXT, A_WP, A_IDX} addr_sel_t;
  typedef enum logic {W_ZERO, W_VALUE} wdata_sel_t;
  typedef enum logic [1:0] {B_HOLD, B_CLEAR, B_ADD} base_op_t;
  typedef enum logic [1:0] {P_HOLD, P_LOAD, P_INC} wp_op_t;

  typedef struct packed {
    cond_t            cond;
    logic [UPC_W-1:0] target;
    mem_op_t          mem;
    addr_sel_t        addr;
    wdata_sel_t       wdata;
    base_op_t         base;
    wp_op_t           wp;
    logic             erase;
    logic             count;
    logic             hit;
    logic             capture;
    logic             finish;
  } cw_t;

  // Status the datapath reports for the jump conditions
  typedef struct packed {
    logic is_read;
    logic open;
    logic slot_out;
    logic hdr_erased;
    logic hdr_nonzero;
    logic last_slot;
    logic idx_out;
  } flags_t;

  localparam cw_t UC_NOP = '{
    cond: C_NEVER, target: '0, mem: M_NONE, addr: A_BASE, wdata: W_ZERO,
    base: B_HOLD, wp: P_HOLD, erase: 1'b0, count: 1'b0, hit: 1'b0,
    capture: 1'b0, finish: 1'b0
  };

  // Step addresses
  localparam logic [UPC_W-1:0] U_DISPATCH = UPC_W'(0);
  localparam logic [UPC_W-1:0] U_A_OPEN   = UPC_W'(1);
  localparam logic [UPC_W-1:0] U_A_SCAN   = UPC_W'(2);
  localparam logic [UPC_W-1:0] U_A_RD     = UPC_W'(3);
  localparam logic [UPC_W-1:0] U_A_TEST   = UPC_W'(4);
  localparam logic [UPC_W-1:0] U_A_STEP   = UPC_W'(5);
  localparam logic [UPC_W-1:0] U_A_ERASE  = UPC_W'(6);
  localparam logic [UPC_W-1:0] U_A_HDR    = UPC_W'(7);
  localparam logic [UPC_W-1:0] U_A_DATA   = UPC_W'(8);
  localparam logic [UPC_W-1:0] U_R_SCAN   = UPC_W'(9);
  localparam logic [UPC_W-1:0] U_R_RD     = UPC_W'(10);
  localparam logic [UPC_W-1:0] U_R_HDR    = UPC_W'(11);
  localparam logic [UPC_W-1:0] U_R_LAST   = UPC_W'(12);
  localparam logic [UPC_W-1:0] U_R_RDNX   = UPC_W'(13);
  localparam logic [UPC_W-1:0] U_R_NEXT   = UPC_W'(14);
  localparam logic [UPC_W-1:0] U_R_ADV    = UPC_W'(15);
  localparam logic [UPC_W-1:0] U_R_SKIP   = UPC_W'(16);
  localparam logic [UPC_W-1:0] U_R_HIT    = UPC_W'(17);
  localparam logic [UPC_W-1:0] U_R_RDW    = UPC_W'(18);
  localparam logic [UPC_W-1:0] U_R_CAP    = UPC_W'(19);
  localparam logic [UPC_W-1:0] U_R_DONE   = UPC_W'(20);

  // Control store: one word per step
  function automatic cw_t ucode(input logic [UPC_W-1:0] upc);
    cw_t w;
    w = UC_NOP;
    case (upc)
      U_DISPATCH: begin
        w.cond = C_IS_READ; w.target = U_R_SCAN;
      end
      U_A_OPEN: begin
        w.cond = C_OPEN; w.target = U_A_DATA;
      end
      U_A_SCAN: begin
        w.cond = C_SLOT_OUT; w.target = U_A_ERASE;
      end
      U_A_RD: begin
        w.mem = M_READ; w.addr = A_BASE;
      end
      U_A_TEST: begin
        w.cond = C_HDR_ERASED; w.target = U_A_HDR;
      end
      U_A_STEP: begin
        w.base = B_ADD; w.cond = C_ALWAYS; w.target = U_A_SCAN;
      end
      U_A_ERASE: begin
        w.erase = 1'b1; w.base = B_CLEAR;
      end
      U_A_HDR: begin
        w.mem = M_WRITE; w.addr = A_BASE; w.wdata = W_ZERO; w.wp = P_LOAD;
      end
      U_A_DATA: begin
        w.mem = M_WRITE; w.addr = A_WP; w.wdata = W_VALUE; w.wp = P_INC;
        w.count = 1'b1; w.finish = 1'b1;
      end
      U_R_SCAN: begin
        w.cond = C_SLOT_OUT; w.target = U_R_DONE;
      end
      U_R_RD: begin
        w.mem = M_READ; w.addr = A_BASE;
      end
      U_R_HDR: begin
        w.cond = C_HDR_NONZERO; w.target = U_R_SKIP;
      end
      U_R_LAST: begin
        w.cond = C_LAST_SLOT; w.target = U_R_HIT;
      end
      U_R_RDNX: begin
        w.mem = M_READ; w.addr = A_NEXT;
      end
      U_R_NEXT: begin
        w.cond = C_HDR_ERASED; w.target = U_R_HIT;
      end
      U_R_ADV: begin
        w.base = B_ADD; w.cond = C_ALWAYS; w.target = U_R_HDR;
      end
      U_R_SKIP: begin
        w.base = B_ADD; w.cond = C_ALWAYS; w.target = U_R_SCAN;
      end
      U_R_HIT: begin
        w.hit = 1'b1; w.cond = C_IDX_OUT; w.target = U_R_DONE;
      end
      U_R_RDW: begin
        w.mem = M_READ; w.addr = A_IDX;
      end
      U_R_CAP: begin
        w.capture = 1'b1;
      end
      U_R_DONE: begin
        w.finish = 1'b1;
      end
      default: begin
        w.finish = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/fprl_ram.sv @@
// Generic single-port RAM with registered read data.
module fprl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write, or read into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[addr];
    end
  end

endmodule

@@ hw/rtl/fprl_useq.sv @@
// Microcode sequencer: step counter, control store and conditional jumps.
module fprl_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  fprl_pkg::flags_t flags,
  output logic            busy,
  output fprl_pkg::cw_t   ctrl
);
  import fprl_pkg::*;

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             busy_r, busy_nxt;
  cw_t              cw;
  logic             jump;
  logic             accept;

  assign accept = start & ~busy_r;
  assign cw     = ucode(upc_r);
  assign busy   = busy_r;
  assign ctrl   = busy_r ? cw : UC_NOP;

  // Evaluate the jump condition of the current step
  always_comb begin
    case (cw.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_IS_READ:     jump = flags.is_read;
      C_OPEN:        jump = flags.open;
      C_SLOT_OUT:    jump = flags.slot_out;
      C_HDR_ERASED:  jump = flags.hdr_erased;
      C_HDR_NONZERO: jump = flags.hdr_nonzero;
      C_LAST_SLOT:   jump = flags.last_slot;
      C_IDX_OUT:     jump = flags.idx_out;
      default:       jump = 1'b0;
    endcase
  end

  // Advance or jump; drop back to idle on the finishing step
  always_comb begin
    upc_nxt  = upc_r;
    busy_nxt = busy_r;
    if (accept) begin
      upc_nxt  = U_DISPATCH;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      upc_nxt = jump ? cw.target : upc_r + UPC_W'(1);
      if (cw.finish) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r  <= U_DISPATCH;
      busy_r <= 1'b0;
    end else begin
      upc_r  <= upc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

@@ hw/rtl/fprl_dpath.sv @@
// Datapath: page store with erase bits, slot pointers, record counter, result register.
module fprl_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  fprl_pkg::in_item_t             in_data,
  input  logic                           cfg_we,
  input  logic [fprl_pkg::CNT_W-1:0]     cfg_data,
  input  fprl_pkg::cw_t                  ctrl,
  output fprl_pkg::flags_t               flags,
  output logic                           out_valid,
  output fprl_pkg::out_item_t            out_data
);
  import fprl_pkg::*;

  // Latched item
  logic                 cmd_r;
  logic [WORD_BITS-1:0] val_r;
  logic [CNT_W-1:0]     idx_r;

  // Record state and configuration
  logic [CNT_W-1:0]     pc_r;
  logic [CNT_W-1:0]     ww_r, ww_nxt;
  logic [PTR_W-1:0]     base_r, base_nxt;
  logic [PTR_W-1:0]     wp_r, wp_nxt;
  logic [PAGE_ENTRIES-1:0] vld_r, vld_nxt;
  logic                 vld_q_r;

  // Per-item result state
  logic [WORD_BITS-1:0] rv_r;
  logic                 found_r, erased_r, done_r;
  logic                 out_valid_r;
  out_item_t            out_r, out_nxt;

  logic [CNT_W-1:0]     p_eff;
  logic [SUM_W-1:0]     len_w, base_w, nb_w, nn_w, idx_w, wp_w, addr_w;
  logic                 in_page;
  logic [ADDR_W-1:0]    ram_addr;
  logic                 ram_we, ram_re;
  logic [WORD_BITS-1:0] ram_wdata, ram_q, rd_eff;
  logic [CNT_W:0]       ww_sum;
  logic                 closes;

  // Clamp the payload count to a usable slot length
  always_comb begin
    p_eff = pc_r;
    if (pc_r == '0) begin
      p_eff = CNT_W'(1);
    end
    if (SUM_W'(pc_r) > SUM_W'(PAGE_ENTRIES - 1)) begin
      p_eff = CNT_W'(PAGE_ENTRIES - 1);
    end
  end

  // Slot arithmetic
  assign len_w  = SUM_W'(p_eff) + SUM_W'(1);
  assign base_w = SUM_W'(base_r);
  assign nb_w   = base_w + len_w;
  assign nn_w   = nb_w + len_w;
  assign idx_w  = base_w + SUM_W'(1) + SUM_W'(idx_r);
  assign wp_w   = SUM_W'(wp_r);

  // Pick the store address
  always_comb begin
    case (ctrl.addr)
      A_BASE:  addr_w = base_w;
      A_NEXT:  addr_w = nb_w;
      A_WP:    addr_w = wp_w;
      A_IDX:   addr_w = idx_w;
      default: addr_w = base_w;
    endcase
  end

  assign in_page   = addr_w < SUM_W'(PAGE_ENTRIES);
  assign ram_addr  = addr_w[ADDR_W-1:0];
  assign ram_we    = (ctrl.mem == M_WRITE) && in_page;
  assign ram_re    = (ctrl.mem == M_READ) && in_page;
  assign ram_wdata = (ctrl.wdata == W_VALUE) ? val_r : '0;

  fprl_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (PAGE_ENTRIES)
  ) u_page (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  // An entry not programmed since the last erase reads as erased
  assign rd_eff = vld_q_r ? ram_q : ERASED_WORD;

  assign flags.is_read     = cmd_r == CMD_READ;
  assign flags.open        = ww_r != '0;
  assign flags.slot_out    = nb_w > SUM_W'(PAGE_ENTRIES);
  assign flags.last_slot   = nn_w > SUM_W'(PAGE_ENTRIES);
  assign flags.hdr_erased  = rd_eff == ERASED_WORD;
  assign flags.hdr_nonzero = rd_eff != '0;
  assign flags.idx_out     = idx_r >= p_eff;

  assign ww_sum = {1'b0, ww_r} + (CNT_W + 1)'(1);
  assign closes = ww_sum >= {1'b0, p_eff};

  // Next values of the pointers, counter and erase bits
  always_comb begin
    base_nxt = base_r;
    wp_nxt   = wp_r;
    ww_nxt   = ww_r;
    vld_nxt  = vld_r;
    case (ctrl.base)
      B_CLEAR: base_nxt = '0;
      B_ADD:   base_nxt = nb_w[PTR_W-1:0];
      default: base_nxt = base_r;
    endcase
    if (accept) begin
      base_nxt = '0;
    end
    case (ctrl.wp)
      P_LOAD:  wp_nxt = base_r + PTR_W'(1);
      P_INC:   wp_nxt = wp_r + PTR_W'(1);
      default: wp_nxt = wp_r;
    endcase
    if (ctrl.count) begin
      ww_nxt = closes ? '0 : ww_sum[CNT_W-1:0];
    end
    if (cfg_we) begin
      ww_nxt = '0;
    end
    if (ctrl.erase) begin
      vld_nxt = '0;
    end else if (ram_we) begin
      vld_nxt[ram_addr] = 1'b1;
    end
  end

  // Compose the result word
  always_comb begin
    out_nxt.read_value   = (cmd_r == CMD_READ) ? 32'(rv_r) : '0;
    out_nxt.record_found = (cmd_r == CMD_READ) & found_r;
    out_nxt.page_erased  = (cmd_r == CMD_APPEND) & erased_r;
    out_nxt.record_done  = (cmd_r == CMD_APPEND) & (ctrl.count ? closes : done_r);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PAYLOAD_RESET;
      ww_r        <= '0;
      wp_r        <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pc_r <= cfg_data;
      end
      ww_r        <= ww_nxt;
      wp_r        <= wp_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= ctrl.finish;
    end
  end

  // Item payload, scan pointer and per-item flags
  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    if (accept) begin
      cmd_r    <= in_data.command;
      val_r    <= in_data.word_value[WORD_BITS-1:0];
      idx_r    <= in_data.word_index;
      rv_r     <= ERASED_WORD;
      found_r  <= 1'b0;
      erased_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      if (ctrl.capture) begin
        rv_r <= rd_eff;
      end
      if (ctrl.hit) begin
        found_r <= 1'b1;
      end
      if (ctrl.erase) begin
        erased_r <= 1'b1;
      end
      if (ctrl.count) begin
        done_r <= closes;
      end
    end
    if (ram_re) begin
      vld_q_r <= vld_r[ram_addr];
    end
    if (ctrl.finish) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hw/rtl/flash_page_record_log.sv @@
// Top level of the flash page record log: sequencer, datapath and port glue.
//
// Append-only record log in one 240-word page. An item is taken when start is
// high and busy is low. Its single result shows on out_data with out_valid for
// one cycle, the first cycle in which busy reads low again, and cannot be held
// off. The control program runs one step at a time and the page store has
// one port, so the slot scan sets the time. An append that continues an open
// record skips the scan. An append that opens a record takes longest when the
// page is full and gets erased, and a read takes longest when every header is
// zero. A page holds S = floor(240 / (P + 1)) slots, where P is the payload
// count (S = 120 for P = 1). Per-entry valid bits, cleared at reset and on
// erase, make an unprogrammed word read as all ones, so no clearing pass
// follows reset or an erase. payload_count is written over cfg_valid/cfg_ready
// while busy is low and closes any open record.
module flash_page_record_log (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  fprl_pkg::in_item_t         in_data,
  output logic                       out_valid,
  output fprl_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fprl_pkg::CNT_W-1:0] cfg_data
);
  import fprl_pkg::*;

  flags_t flags;
  cw_t    ctrl;
  logic   accept;
  logic   cfg_we;

  assign accept    = start & ~busy;
  assign cfg_ready = ~busy;
  assign cfg_we    = cfg_valid & cfg_ready;

  fprl_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  fprl_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .flags     (flags),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // A result only follows the end of a busy period
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result word without a finished item");

  // An accepted item always starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // One result per item: never two strobes in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // Read and append flags never mix in one result
  a_flag_mix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.record_found &&
                    (out_data.page_erased || out_data.record_done)))
    else $error("read and append status in one result");
`endif

endmodule

@@ bench/tb_flash_page_record_log.sv @@
// Self-checking testbench for the flash page record log: predicted page contents vs. results.
module tb_flash_page_record_log;
  timeunit 1ns;
  timeprecision 1ps;

  import fprl_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int NUM_PHASES  = 7;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  in_item_t            in_data   = '0;
  logic                out_valid;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CNT_W-1:0]    cfg_data  = '0;

  // Words waiting to be sent and results still owed by the block
  in_item_t  pending_words [$];
  out_item_t expected_results [$];
  int        words_left    = 0;
  int        gap_left      = 0;
  int        accepted_count = 0;
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  logic      bursty         = 1'b1;
  logic      quiet          = 1'b0;

  // Shadow copy of the page and the record bookkeeping
  logic [WORD_BITS-1:0] page_model [PAGE_ENTRIES];
  int unsigned          wp_model;
  int unsigned          open_words;
  logic [CNT_W-1:0]     payload_reg;

  flash_page_record_log uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Apply one word to the shadow page and return the result it must give
  function automatic out_item_t predict_log(input in_item_t it);
    out_item_t   r;
    int unsigned p, len, slots, base, s;
    logic        hit, next_erased;
    r = '0;
    base = 0;
    p = (payload_reg == 0) ? 1 :
        ((payload_reg > PAGE_ENTRIES - 1) ? PAGE_ENTRIES - 1 : payload_reg);
    len = p + 1;
    slots = PAGE_ENTRIES / len;
    if (it.command == CMD_APPEND) begin
      if (open_words == 0) begin
        hit = 1'b0;
        for (s = 0; s < slots && !hit; s++) begin
          if (page_model[s * len] == ERASED_WORD) begin
            base = s * len;
            hit = 1'b1;
          end
        end
        // page full: erase and restart at slot 0
        if (!hit) begin
          foreach (page_model[i]) page_model[i] = ERASED_WORD;
          base = 0;
          r.page_erased = 1'b1;
        end
        page_model[base] = '0;
        wp_model = base + 1;
      end
      if (wp_model < PAGE_ENTRIES) page_model[wp_model] = it.word_value;
      wp_model++;
      open_words++;
      if (open_words >= p) begin
        open_words = 0;
        r.record_done = 1'b1;
      end
    end else begin
      r.read_value = ERASED_WORD;
      hit = 1'b0;
      for (s = 0; s < slots && !hit; s++) begin
        base = s * len;
        // the header past the last slot always counts as erased
        next_erased = (s + 1 == slots) || (page_model[base + len] == ERASED_WORD);
        if (page_model[base] == '0 && next_erased) begin
          hit = 1'b1;
          if (it.word_index < p) r.read_value = page_model[base + 1 + it.word_index];
        end
      end
      r.record_found = hit;
    end
    return r;
  endfunction

  // Driver: hold start until taken, then advance to the next word or idle a burst
  always @(posedge clk) begin : drive
    logic go;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      go = start;
      if (start && !busy) begin
        expected_results.push_back(predict_log(in_data));
        words_left--;
        accepted_count++;
        go = 1'b0;
        if (accepted_count % 48 == 0) bursty <= $urandom_range(0, 1);
      end
      if (!go) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_words.size() != 0) begin
          if (!quiet && bursty && $urandom_range(0, 3) == 0) begin
            gap_left <= $urandom_range(1, 4) - 1;
          end else begin
            in_data <= pending_words.pop_front();
            go = 1'b1;
          end
        end
      end
      start <= go;
    end
  end

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin : check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: value=%h found=%b erased=%b done=%b",
                   out_data.read_value, out_data.record_found,
                   out_data.page_erased, out_data.record_done);
      end else begin
        want = expected_results.pop_front();
        if (out_data.read_value !== want.read_value ||
            out_data.record_found !== want.record_found ||
            out_data.page_erased !== want.page_erased ||
            out_data.record_done !== want.record_done) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result mismatch: got value=%h found=%b erased=%b done=%b,",
                      " want value=%h found=%b erased=%b done=%b"},
                     out_data.read_value, out_data.record_found,
                     out_data.page_erased, out_data.record_done,
                     want.read_value, want.record_found,
                     want.page_erased, want.record_done);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_word(input logic cmd, input logic [31:0] value, input logic [6:0] index);
    in_item_t it;
    it.command    = cmd;
    it.word_value = value;
    it.word_index = index;
    words_left++;
    pending_words.push_back(it);
  endtask

  // Wait until every word is taken and every result has come back
  task automatic drain();
    while (words_left != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write payload_count while the block is idle; an open record gets closed
  task automatic write_payload_count(input logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    payload_reg = value;
    open_words  = 0;
    cfg_valid  <= 1'b0;
  endtask

  // Random mix of record words and reads, mostly in-range indexes
  task automatic queue_phase(input logic [CNT_W-1:0] cfg_value, input int count,
                             input int read_pct);
    int          p;
    logic [31:0] value;
    logic [6:0]  index;
    p = (cfg_value == 0) ? 1 : ((cfg_value > PAGE_ENTRIES - 1) ? PAGE_ENTRIES - 1 : cfg_value);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 7))
        0:       value = '0;
        1:       value = '1;
        default: value = $urandom;
      endcase
      if ($urandom_range(0, 4) == 0) index = $urandom_range(0, 127);
      else index = $urandom_range(0, (p > 127) ? 127 : p);
      if ($urandom_range(0, 99) < read_pct) push_word(CMD_READ, value, index);
      else push_word(CMD_APPEND, value, index);
    end
  endtask

  logic [CNT_W-1:0] phase_cfg   [NUM_PHASES] = '{7'd5, 7'd0, 7'd127, 7'd119, 7'd2, 7'd59, 7'd1};
  int               phase_items [NUM_PHASES] = '{180, 230, 420, 330, 150, 150, 90};
  int               phase_reads [NUM_PHASES] = '{25, 25, 15, 15, 25, 20, 30};

  initial begin
    foreach (page_model[i]) page_model[i] = ERASED_WORD;
    wp_model    = 0;
    open_words  = 0;
    payload_reg = PAYLOAD_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty page, field extremes, out-of-range index, partial record
    push_word(CMD_READ, 32'h0, 7'd0);
    push_word(CMD_READ, 32'hFFFF_FFFF, 7'd127);
    push_word(CMD_APPEND, 32'h0000_0000, 7'd127);
    push_word(CMD_APPEND, 32'hFFFF_FFFF, 7'd0);
    push_word(CMD_APPEND, 32'hA5A5_A5A5, 7'd0);
    push_word(CMD_APPEND, 32'h5A5A_5A5A, 7'd0);
    push_word(CMD_APPEND, 32'h0000_0001, 7'd0);
    push_word(CMD_READ, 32'h0, 7'd0);
    push_word(CMD_READ, 32'h0, 7'd4);
    push_word(CMD_READ, 32'h0, 7'd5);
    push_word(CMD_READ, 32'hFFFF_FFFF, 7'd127);
    push_word(CMD_APPEND, 32'h8000_0000, 7'd0);
    push_word(CMD_APPEND, 32'h7FFF_FFFF, 7'd0);
    push_word(CMD_READ, 32'h0, 7'd1);
    push_word(CMD_READ, 32'h0, 7'd4);
    push_word(CMD_APPEND, 32'h1234_5678, 7'd0);
    push_word(CMD_APPEND, 32'h9ABC_DEF0, 7'd0);
    push_word(CMD_APPEND, 32'h0F0F_0F0F, 7'd0);
    push_word(CMD_READ, 32'h0, 7'd2);
    push_word(CMD_APPEND, 32'hDEAD_BEEF, 7'd0);
    push_word(CMD_APPEND, 32'hCAFE_F00D, 7'd0);
    drain();

    // Rewrite the register mid-record: the next word must open a fresh record
    write_payload_count(7'd5);
    push_word(CMD_APPEND, 32'h0BAD_F00D, 7'd0);
    push_word(CMD_READ, 32'h0, 7'd0);
    drain();

    // Random phases over several record sizes, the extremes among them
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      quiet = (ph == NUM_PHASES - 1);
      write_payload_count(phase_cfg[ph]);
      queue_phase(phase_cfg[ph], phase_items[ph], phase_reads[ph]);
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/fprl_pkg.sv
hw/rtl/fprl_ram.sv
hw/rtl/fprl_useq.sv
hw/rtl/fprl_dpath.sv
hw/rtl/flash_page_record_log.sv
bench/tb_flash_page_record_log.sv
